// File: rtl/core/assert_macros.svh
// Assertion macros used by grid_influence_propagation.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge, off during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the next cycle, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/gip_pkg.sv
// Package for the grid influence propagation block: sizes, codes, payload types.
// No dependencies.
package gip_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = 6;
  localparam int COL_W    = 6;
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int CNT_W    = 13;
  localparam int SIZE_W   = 7;
  localparam int VAL_W    = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_AW   = 3;

  // Command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_PROP  = 2'd2;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_MAP_ROWS = 3'd0;
  localparam logic [CFG_AW-1:0] REG_MAP_COLS = 3'd1;
  localparam logic [CFG_AW-1:0] REG_DUAL     = 3'd2;
  localparam logic [CFG_AW-1:0] REG_ORTH     = 3'd3;
  localparam logic [CFG_AW-1:0] REG_DIAG     = 3'd4;
  localparam logic [CFG_AW-1:0] REG_GROWTH   = 3'd5;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] cell_value;
    logic                    cell_wall;
  } item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic                    read_wall;
    logic                    pass_done;
    logic                    pass_skipped;
  } result_t;

  // Row offset (0..2, meaning -1..+1) of 3x3 window slot k, row-major
  function automatic logic [1:0] win_dr(input logic [3:0] k);
    logic [1:0] d;
    case (k)
      4'd0, 4'd1, 4'd2: d = 2'd0;
      4'd3, 4'd4, 4'd5: d = 2'd1;
      default:          d = 2'd2;
    endcase
    return d;
  endfunction

  // Column offset of window slot k
  function automatic logic [1:0] win_dc(input logic [3:0] k);
    logic [1:0] d;
    case (k)
      4'd0, 4'd3, 4'd6: d = 2'd0;
      4'd1, 4'd4, 4'd7: d = 2'd1;
      default:          d = 2'd2;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/core/gip_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gip_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/grid_influence_propagation.sv
// Top level of the grid influence propagation block.
// Depends on gip_pkg, gip_ram and assert_macros.svh.
//
// Command-driven influence map. A write is stored on acceptance; a read returns its
// result on the cycle after acceptance. A propagate command holds busy through
// one scan sweep to count nonzero cells, then a step per cell in use (nine
// window reads through the single read port of the value memory, eight
// products through one shared multiplier, one growth product, one write), then
// a copy sweep back from the next-value memory. A pass is skipped when no cell
// in use is nonzero. After reset the block clears its value and wall memories
// with busy high; configuration writes are taken at all times. Results carry
// no back-pressure: result_valid is high for exactly one cycle per transaction
// result.
`include "assert_macros.svh"

module grid_influence_propagation (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  gip_pkg::item_t                   item,
  output logic                             result_valid,
  output gip_pkg::result_t                 result,
  input  logic                             cfg_we,
  input  logic [gip_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [gip_pkg::CFG_W-1:0]        cfg_data
);
  import gip_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CLEAR    = 4'd1;
  localparam logic [3:0] S_SCAN     = 4'd2;
  localparam logic [3:0] S_SCAN_END = 4'd3;
  localparam logic [3:0] S_WIN      = 4'd4;
  localparam logic [3:0] S_MUL      = 4'd5;
  localparam logic [3:0] S_GROW     = 4'd6;
  localparam logic [3:0] S_GROW2    = 4'd7;
  localparam logic [3:0] S_COPY     = 4'd8;
  localparam logic [3:0] S_COPY_END = 4'd9;
  localparam logic [3:0] S_FIN      = 4'd10;

  // Configuration registers
  logic [SIZE_W-1:0] map_rows, map_cols;
  logic              dual_mode;
  logic [15:0]       orth_factor, diag_factor, growth;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_rows    <= SIZE_W'(40);
      map_cols    <= SIZE_W'(40);
      dual_mode   <= 1'b0;
      orth_factor <= 16'hFFFF;
      diag_factor <= 16'hFFFF;
      growth      <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAP_ROWS: map_rows    <= cfg_data[SIZE_W-1:0];
        REG_MAP_COLS: map_cols    <= cfg_data[SIZE_W-1:0];
        REG_DUAL:     dual_mode   <= cfg_data[0];
        REG_ORTH:     orth_factor <= cfg_data;
        REG_DIAG:     diag_factor <= cfg_data;
        REG_GROWTH:   growth      <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [SIZE_W-1:0] rows_used, cols_used;
  assign rows_used = (map_rows > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : map_rows;
  assign cols_used = (map_cols > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : map_cols;

  // Control state
  logic [3:0]       state;
  logic [ROW_W-1:0] cr;
  logic [COL_W-1:0] cc;
  logic [3:0]       k, w_k, m;
  logic             w_vld, s_vld, c_vld, p_keep;
  logic [ADDR_W-1:0] c_addr;
  logic [CNT_W-1:0] nonzero_count, cnt_next;
  logic             skipped;
  logic             rd_pend, rd_in;

  // Datapath registers
  logic signed [VAL_W-1:0] win_val [9];
  logic                    win_wall [9];
  logic signed [32:0]      prod;
  logic signed [16:0]      best;
  logic signed [34:0]      gprod;

  // Memory ports
  logic              v_we, w_we, n_we;
  logic [ADDR_W-1:0] v_waddr, v_raddr, n_waddr, n_raddr;
  logic [VAL_W-1:0]  v_wdata, v_q, n_wdata, n_q;
  logic              w_wdata, w_q;

  gip_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_val_ram (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata), .raddr(v_raddr), .rdata(v_q)
  );
  gip_ram #(.WIDTH(1), .DEPTH(CELLS)) u_wall_ram (
    .clk(clk), .we(w_we), .waddr(v_waddr), .wdata(w_wdata), .raddr(v_raddr), .rdata(w_q)
  );
  gip_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_next_ram (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata), .raddr(n_raddr), .rdata(n_q)
  );

  // Handshake decode
  logic accept, in_map, last_cell, last_clear;
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign in_map    = ({1'b0, item.row} < rows_used) && ({1'b0, item.col} < cols_used);
  assign last_cell = ({1'b0, cr} == rows_used - SIZE_W'(1)) &&
                     ({1'b0, cc} == cols_used - SIZE_W'(1));
  assign last_clear = (cr == ROW_W'(MAX_ROWS - 1)) && (cc == COL_W'(MAX_COLS - 1));

  // Window read address for slot k
  logic [ROW_W-1:0] wr_row;
  logic [COL_W-1:0] wr_col;
  assign wr_row = cr + ROW_W'(win_dr(k)) - ROW_W'(1);
  assign wr_col = cc + COL_W'(win_dc(k)) - COL_W'(1);

  // Neighbor selection for slot m: map bounds and wall cuts
  logic [1:0]  m_dr, m_dc;
  logic [7:0]  m_rr, m_cc;
  logic [3:0]  m_ia, m_ib, m_sel;
  logic        m_diag, m_cut, m_keep;
  logic [15:0] m_factor;
  always_comb begin
    m_dr     = win_dr(m);
    m_dc     = win_dc(m);
    m_rr     = {2'b00, cr} + {6'b0, m_dr} - 8'd1;
    m_cc     = {2'b00, cc} + {6'b0, m_dc} - 8'd1;
    m_diag   = (m_dr != 2'd1) && (m_dc != 2'd1);
    m_ia     = {2'b00, m_dr} * 4'd3 + 4'd1;
    m_ib     = 4'd3 + {2'b00, m_dc};
    m_sel    = (m < 4'd9) ? m : 4'd4;
    m_cut    = m_diag ? (win_wall[m_ia] | win_wall[m_ib]) : win_wall[m_sel];
    m_keep   = (m < 4'd9) && (m != 4'd4) && !m_cut &&
               (m_rr < {1'b0, rows_used}) && (m_cc < {1'b0, cols_used});
    m_factor = m_diag ? diag_factor : orth_factor;
  end

  // Rounded scaled neighbor and best-value update
  logic signed [32:0] prod_rnd;
  logic signed [16:0] scaled, abs_s, abs_b;
  logic               take;
  always_comb begin
    prod_rnd = prod + 33'sd32768;
    scaled   = prod_rnd[32:16];
    abs_s    = scaled[16] ? -scaled : scaled;
    abs_b    = best[16] ? -best : best;
    take     = dual_mode ? (abs_s > abs_b) : (scaled > best);
  end

  // Growth step toward the best value
  logic signed [17:0] diff;
  logic signed [34:0] gprod_rnd;
  logic signed [18:0] adj;
  logic signed [18:0] new_full;
  always_comb begin
    diff      = 18'(best) - 18'(win_val[4]);
    gprod_rnd = gprod + 35'sd32768;
    adj       = gprod_rnd[34:16];
    new_full  = 19'(win_val[4]) + adj;
  end

  assign cnt_next = nonzero_count + CNT_W'(s_vld && (v_q != '0));

  // Memory port steering
  always_comb begin
    v_we    = 1'b0;
    w_we    = 1'b0;
    v_waddr = {item.row, item.col};
    v_wdata = item.cell_value;
    w_wdata = item.cell_wall;
    v_raddr = {item.row, item.col};
    n_we    = (state == S_GROW2);
    n_waddr = {cr, cc};
    n_wdata = win_wall[4] ? '0 : new_full[VAL_W-1:0];
    n_raddr = {cr, cc};
    case (state)
      S_IDLE: begin
        v_we = accept && (item.cmd == CMD_WRITE) && in_map;
        w_we = v_we;
      end
      S_CLEAR: begin
        v_we    = 1'b1;
        w_we    = 1'b1;
        v_waddr = {cr, cc};
        v_wdata = '0;
        w_wdata = 1'b0;
      end
      S_SCAN: v_raddr = {cr, cc};
      S_WIN:  v_raddr = {wr_row, wr_col};
      default: ;
    endcase
    if (c_vld) begin
      v_we    = 1'b1;
      v_waddr = c_addr;
      v_wdata = n_q;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      cr            <= '0;
      cc            <= '0;
      k             <= '0;
      m             <= '0;
      w_vld         <= 1'b0;
      s_vld         <= 1'b0;
      c_vld         <= 1'b0;
      p_keep        <= 1'b0;
      nonzero_count <= '0;
      skipped       <= 1'b0;
      rd_pend       <= 1'b0;
    end else begin
      s_vld   <= (state == S_SCAN);
      w_vld   <= (state == S_WIN) && (k < 4'd9);
      c_vld   <= (state == S_COPY);
      p_keep  <= (state == S_MUL) && m_keep;
      rd_pend <= accept && (item.cmd == CMD_READ);
      case (state)
        S_IDLE: begin
          if (accept && (item.cmd == CMD_PROP)) begin
            cr            <= '0;
            cc            <= '0;
            nonzero_count <= '0;
            if (rows_used == '0 || cols_used == '0) begin
              skipped <= 1'b1;
              state   <= S_FIN;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_CLEAR: begin
          if (last_clear) begin
            cr    <= '0;
            cc    <= '0;
            state <= S_IDLE;
          end else if (cc == COL_W'(MAX_COLS - 1)) begin
            cc <= '0;
            cr <= cr + ROW_W'(1);
          end else begin
            cc <= cc + COL_W'(1);
          end
        end
        S_SCAN: begin
          nonzero_count <= cnt_next;
          if (last_cell) begin
            state <= S_SCAN_END;
          end else if ({1'b0, cc} == cols_used - SIZE_W'(1)) begin
            cc <= '0;
            cr <= cr + ROW_W'(1);
          end else begin
            cc <= cc + COL_W'(1);
          end
        end
        S_SCAN_END: begin
          nonzero_count <= cnt_next;
          cr            <= '0;
          cc            <= '0;
          k             <= '0;
          if (cnt_next == '0) begin
            skipped <= 1'b1;
            state   <= S_FIN;
          end else begin
            skipped <= 1'b0;
            state   <= S_WIN;
          end
        end
        S_WIN: begin
          if (k == 4'd9) begin
            m     <= '0;
            state <= S_MUL;
          end else begin
            k <= k + 4'd1;
          end
        end
        S_MUL: begin
          if (m == 4'd9) begin
            state <= S_GROW;
          end else begin
            m <= m + 4'd1;
          end
        end
        S_GROW: state <= S_GROW2;
        S_GROW2: begin
          k <= '0;
          if (last_cell) begin
            cr    <= '0;
            cc    <= '0;
            state <= S_COPY;
          end else begin
            state <= S_WIN;
            if ({1'b0, cc} == cols_used - SIZE_W'(1)) begin
              cc <= '0;
              cr <= cr + ROW_W'(1);
            end else begin
              cc <= cc + COL_W'(1);
            end
          end
        end
        S_COPY: begin
          if (last_cell) begin
            state <= S_COPY_END;
          end else if ({1'b0, cc} == cols_used - SIZE_W'(1)) begin
            cc <= '0;
            cr <= cr + ROW_W'(1);
          end else begin
            cc <= cc + COL_W'(1);
          end
        end
        S_COPY_END: state <= S_FIN;
        S_FIN:      state <= S_IDLE;
        default:    state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers: window capture, products, best value
  always_ff @(posedge clk) begin
    c_addr <= {cr, cc};
    rd_in  <= in_map;
    if (w_vld) begin
      win_val[w_k]  <= v_q;
      win_wall[w_k] <= w_q;
    end
    w_k   <= k;
    prod  <= 33'(win_val[m_sel]) * $signed({17'b0, m_factor});
    gprod <= 35'(diff) * $signed({19'b0, growth});
    if (state == S_WIN) begin
      best <= '0;
    end else if (p_keep && take) begin
      best <= scaled;
    end
  end

  // Result port
  always_comb begin
    result_valid = rd_pend || (state == S_FIN);
    result       = '0;
    if (rd_pend) begin
      result.read_value = rd_in ? v_q : '0;
      result.read_wall  = rd_in ? w_q : 1'b0;
    end else begin
      result.pass_done    = (state == S_FIN);
      result.pass_skipped = (state == S_FIN) && skipped;
    end
  end

  // Checks
  `ASSERT_IMPL(a_one_result, rd_pend, state != S_FIN, "read result collides with pass end")
  `ASSERT_NEXT(a_read_reply, accept && item.cmd == CMD_READ, result_valid && !result.pass_done,
               "read transaction gave no result")
  `ASSERT_NEXT(a_prop_busy, accept && item.cmd == CMD_PROP, busy,
               "propagate transaction did not raise busy")
  `ASSERT_IMPL(a_copy_quiet, state == S_COPY, !n_we, "next store written during copy")

endmodule
